### rtl/pfd_pkg.sv
package pfd_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CFG_A_W = 3;

    localparam logic [CFG_A_W-1:0] CFG_SYNC_GAP       = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_ACCEPT_LOW     = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_ACCEPT_HIGH    = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_CLAMP_LOW      = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_CLAMP_HIGH     = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_TIMEOUT_LIMIT  = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_FAILSAFE_VALUE = 3'd6;

    localparam logic [DATA_W-1:0] RST_SYNC_GAP       = 16'd3000;
    localparam logic [DATA_W-1:0] RST_ACCEPT_LOW     = 16'd900;
    localparam logic [DATA_W-1:0] RST_ACCEPT_HIGH    = 16'd2100;
    localparam logic [DATA_W-1:0] RST_CLAMP_LOW      = 16'd1000;
    localparam logic [DATA_W-1:0] RST_CLAMP_HIGH     = 16'd2000;
    localparam logic [DATA_W-1:0] RST_TIMEOUT_LIMIT  = 16'd500;
    localparam logic [DATA_W-1:0] RST_FAILSAFE_VALUE = 16'd500;

    localparam logic CMD_INTERVAL = 1'b0;
    localparam logic CAUSE_FRAME    = 1'b0;
    localparam logic CAUSE_FAILSAFE = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] sync_gap;
        logic [DATA_W-1:0] accept_low;
        logic [DATA_W-1:0] accept_high;
        logic [DATA_W-1:0] clamp_low;
        logic [DATA_W-1:0] clamp_high;
        logic [DATA_W-1:0] timeout_limit;
        logic [DATA_W-1:0] failsafe_value;
    } t_cfg;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_slot_wr;

endpackage

### rtl/pfd_front.sv
module pfd_front #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pfd_pkg::t_cfg             i_cfg,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_cmd,
    input  logic [pfd_pkg::DATA_W-1:0] i_pulse_width,
    input  logic                      i_q_full,
    input  logic                      i_q_empty,
    input  logic                      i_back_busy,
    output logic                      o_q_push,
    output logic                      o_q_cause,
    output pfd_pkg::t_slot_wr         o_slot_wr
);

    localparam int unsigned CW = $clog2(NUM_CHANNELS + 1);

    logic                       r_hold;
    logic                       r_cmd;
    logic [pfd_pkg::DATA_W-1:0] r_pw;
    logic [CW-1:0]              r_cnt;
    logic                       r_fv;
    logic [pfd_pkg::DATA_W-1:0] r_idle;

    logic [pfd_pkg::DATA_W:0]   next_idle;
    logic                       is_tick, fire, is_sync, commit, in_win;
    logic                       need_q, need_idle, go;
    logic [pfd_pkg::DATA_W-1:0] clamped;

    always_comb begin
        is_tick   = (r_cmd != pfd_pkg::CMD_INTERVAL);
        next_idle = {1'b0, r_idle} + 17'd1;
        fire      = next_idle > {1'b0, i_cfg.timeout_limit};
        is_sync   = r_pw > i_cfg.sync_gap;
        commit    = r_fv && (r_cnt == CW'(NUM_CHANNELS));
        in_win    = (r_cnt < CW'(NUM_CHANNELS)) && (r_pw >= i_cfg.accept_low)
                    && (r_pw <= i_cfg.accept_high);
        need_q    = is_tick ? fire : (is_sync && commit);
        need_idle = !is_tick && !is_sync && in_win;
        go        = r_hold && !(need_q && i_q_full)
                    && !(need_idle && (!i_q_empty || i_back_busy));
        if (r_pw < i_cfg.clamp_low) begin
            clamped = i_cfg.clamp_low;
        end else if (r_pw > i_cfg.clamp_high) begin
            clamped = i_cfg.clamp_high;
        end else begin
            clamped = r_pw;
        end
    end

    assign o_full         = r_hold && !go;
    assign o_q_push       = go && need_q;
    assign o_q_cause      = is_tick ? pfd_pkg::CAUSE_FAILSAFE : pfd_pkg::CAUSE_FRAME;
    assign o_slot_wr.en   = go && need_idle;
    assign o_slot_wr.addr = pfd_pkg::IDX_W'(r_cnt);
    assign o_slot_wr.data = clamped - i_cfg.clamp_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_cnt  <= '0;
            r_fv   <= 1'b1;
            r_idle <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_hold <= 1'b1;
                r_cmd  <= i_cmd;
                r_pw   <= i_pulse_width;
            end else if (go) begin
                r_hold <= 1'b0;
            end
            if (go) begin
                if (is_tick) begin
                    r_idle <= fire ? '0 : next_idle[pfd_pkg::DATA_W-1:0];
                end else if (is_sync) begin
                    if (commit) begin
                        r_idle <= '0;
                    end
                    r_fv  <= 1'b1;
                    r_cnt <= '0;
                end else if (in_win) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_fv <= 1'b0;
                end
            end
        end
    end

endmodule

### rtl/pfd_queue.sv
module pfd_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  logic i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output logic o_data
);

    logic [1:0] r_mem;
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_mem[r_wp] <= i_data;
                r_wp        <= !r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'((i_push && !o_full) ? 1 : 0)
                           - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

endmodule

### rtl/pfd_back.sv
module pfd_back #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [pfd_pkg::DATA_W-1:0] i_failsafe_value,
    input  pfd_pkg::t_slot_wr          i_slot_wr,
    input  logic                       i_q_empty,
    input  logic                       i_q_cause,
    output logic                       o_q_pop,
    output logic                       o_busy,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [pfd_pkg::IDX_W-1:0]  o_channel_index,
    output logic [pfd_pkg::DATA_W-1:0] o_channel_value,
    output logic                       o_cause,
    output logic                       o_last_channel
);

    localparam int unsigned KW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [pfd_pkg::DATA_W-1:0] r_slots [NUM_CHANNELS];
    logic                       r_active;
    logic                       r_run_cause;
    logic [KW-1:0]              r_k;
    logic                       r_out_valid;
    logic                       advance;
    logic                       last_k;

    assign o_q_pop = !r_active && !i_q_empty;
    assign o_busy  = r_active;
    assign o_empty = !r_out_valid;
    assign advance = r_active && (!r_out_valid || i_pop);
    assign last_k  = (r_k == KW'(NUM_CHANNELS - 1));

    always_ff @(posedge i_clk) begin
        if (i_slot_wr.en) begin
            r_slots[i_slot_wr.addr[KW-1:0]] <= i_slot_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (o_q_pop) begin
                r_active    <= 1'b1;
                r_run_cause <= i_q_cause;
                r_k         <= '0;
            end else if (advance) begin
                r_k <= r_k + KW'(1);
                if (last_k) begin
                    r_active <= 1'b0;
                end
            end
            if (advance) begin
                r_out_valid     <= 1'b1;
                o_channel_index <= pfd_pkg::IDX_W'(r_k);
                o_channel_value <= (r_run_cause == pfd_pkg::CAUSE_FAILSAFE)
                                   ? i_failsafe_value : r_slots[r_k];
                o_cause         <= r_run_cause;
                o_last_channel  <= last_k;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### rtl/ppm_frame_decoder.sv
// PPM sum-signal decoder. Push one word per edge interval (i_cmd 0) or per
// millisecond tick (i_cmd 1). The front stage holds a word and classifies
// it combinationally; a frame end with all channels filled, or a tick past
// the timeout limit, queues a run that the back stage emits as NUM_CHANNELS
// result words, one per cycle while pop keeps up; the next run leaves the
// queue only once the last one has ended. A channel interval waits in the
// front stage while a run is queued or being emitted, so a slot write after
// a commit waits until every queued run has been emitted; ticks and sync
// gaps pass at one word per cycle unless they must queue a run while two are queued.
module ppm_frame_decoder #(
    parameter int unsigned NUM_CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pfd_pkg::CFG_A_W-1:0]   i_cfg_idx,
    input  logic [pfd_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_cmd,
    input  logic [pfd_pkg::DATA_W-1:0]    i_pulse_width,
    output logic                          empty,
    input  logic                          pop,
    output logic [pfd_pkg::IDX_W-1:0]     o_channel_index,
    output logic [pfd_pkg::DATA_W-1:0]    o_channel_value,
    output logic                          o_cause,
    output logic                          o_last_channel
);

    pfd_pkg::t_cfg     r_cfg;
    pfd_pkg::t_slot_wr slot_wr;
    logic              q_push, q_cause_in, q_pop, q_full, q_empty, q_cause;
    logic              back_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_gap       <= pfd_pkg::RST_SYNC_GAP;
            r_cfg.accept_low     <= pfd_pkg::RST_ACCEPT_LOW;
            r_cfg.accept_high    <= pfd_pkg::RST_ACCEPT_HIGH;
            r_cfg.clamp_low      <= pfd_pkg::RST_CLAMP_LOW;
            r_cfg.clamp_high     <= pfd_pkg::RST_CLAMP_HIGH;
            r_cfg.timeout_limit  <= pfd_pkg::RST_TIMEOUT_LIMIT;
            r_cfg.failsafe_value <= pfd_pkg::RST_FAILSAFE_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfd_pkg::CFG_SYNC_GAP:       r_cfg.sync_gap       <= i_cfg_data;
                pfd_pkg::CFG_ACCEPT_LOW:     r_cfg.accept_low     <= i_cfg_data;
                pfd_pkg::CFG_ACCEPT_HIGH:    r_cfg.accept_high    <= i_cfg_data;
                pfd_pkg::CFG_CLAMP_LOW:      r_cfg.clamp_low      <= i_cfg_data;
                pfd_pkg::CFG_CLAMP_HIGH:     r_cfg.clamp_high     <= i_cfg_data;
                pfd_pkg::CFG_TIMEOUT_LIMIT:  r_cfg.timeout_limit  <= i_cfg_data;
                pfd_pkg::CFG_FAILSAFE_VALUE: r_cfg.failsafe_value <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (push),
        .o_full        (full),
        .i_cmd         (i_cmd),
        .i_pulse_width (i_pulse_width),
        .i_q_full      (q_full),
        .i_q_empty     (q_empty),
        .i_back_busy   (back_busy),
        .o_q_push      (q_push),
        .o_q_cause     (q_cause_in),
        .o_slot_wr     (slot_wr)
    );

    pfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_cause_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_cause)
    );

    pfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_failsafe_value (r_cfg.failsafe_value),
        .i_slot_wr        (slot_wr),
        .i_q_empty        (q_empty),
        .i_q_cause        (q_cause),
        .o_q_pop          (q_pop),
        .o_busy           (back_busy),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_channel_index  (o_channel_index),
        .o_channel_value  (o_channel_value),
        .o_cause          (o_cause),
        .o_last_channel   (o_last_channel)
    );

endmodule
